/* design/scpd_pkg.sv */
// Shared constants, types and the timeout text table for the sync checksum packet deframer.
// No dependencies; imported by scpd_csum and sync_checksum_packet_deframer.
package scpd_pkg;

  localparam int unsigned PACKET_LEN = 5;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CNT_W      = $clog2(PACKET_LEN + 1);
  localparam int unsigned WIN_IDX_W  = $clog2(PACKET_LEN);
  localparam int unsigned TEXT_LEN   = 9;
  localparam int unsigned RUN_MAX    = (PACKET_LEN > TEXT_LEN) ? PACKET_LEN : TEXT_LEN;
  localparam int unsigned RUN_W      = $clog2(RUN_MAX + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

  localparam logic [DATA_W-1:0] SYNC_FIRST_RST    = 8'hFF;
  localparam logic [DATA_W-1:0] SYNC_SECOND_RST   = 8'hFE;
  localparam logic [DATA_W-1:0] TIMEOUT_LIMIT_RST = 8'd100;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_GOOD    = 2'd0;
  localparam kind_t KIND_BADSUM  = 2'd1;
  localparam kind_t KIND_TIMEOUT = 2'd2;

  // Control of the shared checksum adder
  typedef struct packed {
    logic clear;
    logic add;
  } csum_ctl_t;

  // ASCII "over time"
  function automatic logic [DATA_W-1:0] timeout_char(input logic [3:0] idx);
    logic [DATA_W-1:0] c;
    case (idx)
      4'd0:    c = 8'd111;
      4'd1:    c = 8'd118;
      4'd2:    c = 8'd101;
      4'd3:    c = 8'd114;
      4'd4:    c = 8'd32;
      4'd5:    c = 8'd116;
      4'd6:    c = 8'd105;
      4'd7:    c = 8'd109;
      4'd8:    c = 8'd101;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

/* design/scpd_csum.sv */
// Shared 8-bit checksum accumulator, one byte added per cycle while ctl_i.add is set.
// Depends on scpd_pkg.
module scpd_csum
  import scpd_pkg::*;
(
  input  logic              clk_i,
  input  csum_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] data_i,
  output logic [DATA_W-1:0] sum_o
);

  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sum_o = acc_q;

endmodule

/* design/sync_checksum_packet_deframer.sv */
// Sync-word packet deframer with a two's-complement checksum: top level.
// Depends on scpd_pkg and scpd_csum.
//
// Input beats carry either a received byte (mode 0) or a timer tick (mode 1).
// Received bytes collect in a PACKET_LEN-byte pending window. While no header
// is held, the front two bytes are compared with sync_first/sync_second and
// one byte is dropped per mismatch. With a header at the front the block
// waits for a full window, then sums all PACKET_LEN bytes with a single
// shared 8-bit adder, one byte per cycle; a zero total means the last byte is
// the negated sum of the others. A good packet goes out whole as kind 0; a
// bad one sends only its header (kind 1) and the rest is rescanned. If more
// than timeout_limit ticks pass after a header is found, the header is
// dropped and "over time" goes out as kind 2. The last flag marks the final
// beat of each run. Timing: the block takes one beat at a time and holds
// in_ready_o low until parsing of that beat is done. A beat passes through
// the accept in S_IDLE, a header check or byte drop per step in S_PARSE, the
// checksum pass in S_SUM and S_CHECK when a full window is tested, and one
// step per output beat in S_EMIT (longer while the sink stalls). The rate is
// set by the one adder summing a byte a cycle and the window advancing one
// step a cycle, the latter held while the sink stalls. The output register
// lets the next input beat be accepted while the last result beat still
// waits for the sink. Configuration writes take effect at once and are meant
// for idle periods only; there is no read-back.
module sync_checksum_packet_deframer
  import scpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [DATA_W-1:0]    rx_byte_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    out_byte_o,
  output logic [1:0]           kind_o,
  output logic                 last_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PARSE = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [DATA_W-1:0]    sync_first_q, sync_second_q, timeout_limit_q;
  logic [DATA_W-1:0]    win_q [PACKET_LEN];
  logic [DATA_W-1:0]    win_d [PACKET_LEN];
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 hdr_q, hdr_d;
  logic [DATA_W-1:0]    tick_q, tick_d;
  logic [WIN_IDX_W-1:0] sum_idx_q, sum_idx_d;
  kind_t                run_kind_q, run_kind_d;
  logic [RUN_W-1:0]     run_len_q, run_len_d;
  logic [RUN_W-1:0]     run_idx_q, run_idx_d;

  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_byte_q, out_byte_d;
  kind_t                out_kind_q, out_kind_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;

  csum_ctl_t            csum_ctl;
  logic [DATA_W-1:0]    csum_sum;

  scpd_csum u_csum (
    .clk_i  (clk_i),
    .ctl_i  (csum_ctl),
    .data_i (win_q[sum_idx_q]),
    .sum_o  (csum_sum)
  );

  // In S_EMIT, load the output register whenever it is empty or being drained
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    hdr_d       = hdr_q;
    tick_d      = tick_q;
    sum_idx_d   = sum_idx_q;
    run_kind_d  = run_kind_q;
    run_len_d   = run_len_q;
    run_idx_d   = run_idx_q;
    csum_ctl    = '0;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            tick_d = tick_q + 8'd1;
          end else if (cnt_q < CNT_W'(PACKET_LEN)) begin
            // append at the fill position; a full window drops the byte
            for (int i = 0; i < PACKET_LEN; i++) begin
              if (cnt_q == CNT_W'(i)) begin
                win_d[i] = rx_byte_i;
              end
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
          state_d = S_PARSE;
        end
      end
      S_PARSE: begin
        priority if (!hdr_q) begin
          if (cnt_q < CNT_W'(2)) begin
            state_d = S_IDLE;
          end else if (win_q[0] == sync_first_q && win_q[1] == sync_second_q) begin
            hdr_d  = 1'b1;
            tick_d = '0;
          end else begin
            // drop one byte and rescan
            for (int i = 0; i < PACKET_LEN - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            cnt_d = cnt_q - CNT_W'(1);
          end
        end else if (tick_q > timeout_limit_q) begin
          // drop the header, then send the timeout text
          for (int i = 0; i < PACKET_LEN - 2; i++) begin
            win_d[i] = win_q[i+2];
          end
          cnt_d      = cnt_q - CNT_W'(2);
          hdr_d      = 1'b0;
          run_kind_d = KIND_TIMEOUT;
          run_len_d  = RUN_W'(TEXT_LEN);
          run_idx_d  = '0;
          state_d    = S_EMIT;
        end else if (cnt_q >= CNT_W'(PACKET_LEN)) begin
          csum_ctl.clear = 1'b1;
          sum_idx_d      = '0;
          state_d        = S_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        csum_ctl.add = 1'b1;
        if (sum_idx_q == WIN_IDX_W'(PACKET_LEN - 1)) begin
          state_d = S_CHECK;
        end else begin
          sum_idx_d = sum_idx_q + WIN_IDX_W'(1);
        end
      end
      S_CHECK: begin
        // all bytes including the checksum add up to zero on a good packet
        hdr_d     = 1'b0;
        run_idx_d = '0;
        if (csum_sum == '0) begin
          run_kind_d = KIND_GOOD;
          run_len_d  = RUN_W'(PACKET_LEN);
        end else begin
          run_kind_d = KIND_BADSUM;
          run_len_d  = RUN_W'(2);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = run_kind_q;
          out_last_d  = (run_idx_q == run_len_q - RUN_W'(1));
          if (run_kind_q == KIND_TIMEOUT) begin
            out_byte_d = timeout_char(run_idx_q[3:0]);
          end else begin
            // send the front byte and advance the window past it
            out_byte_d = win_q[0];
            for (int i = 0; i < PACKET_LEN - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            cnt_d = cnt_q - CNT_W'(1);
          end
          run_idx_d = run_idx_q + RUN_W'(1);
          if (run_idx_q == run_len_q - RUN_W'(1)) begin
            state_d = S_PARSE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cnt_q           <= '0;
      hdr_q           <= 1'b0;
      tick_q          <= '0;
      out_valid_q     <= 1'b0;
      sync_first_q    <= SYNC_FIRST_RST;
      sync_second_q   <= SYNC_SECOND_RST;
      timeout_limit_q <= TIMEOUT_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hdr_q       <= hdr_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYNC_FIRST:    sync_first_q    <= cfg_wdata_i;
          CFG_SYNC_SECOND:   sync_second_q   <= cfg_wdata_i;
          CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload and sequencer bookkeeping: no reset needed
  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    sum_idx_q  <= sum_idx_d;
    run_kind_q <= run_kind_d;
    run_len_q  <= run_len_d;
    run_idx_q  <= run_idx_d;
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PACKET_LEN))
    else $error("pending count above window size");

  a_hdr_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q |-> (cnt_q >= CNT_W'(2)))
    else $error("header held with fewer than two pending bytes");

  a_idle_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q < CNT_W'(PACKET_LEN)))
    else $error("window full while ready for a new beat");

  a_run_end_reparse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == S_PARSE && out_valid_q && out_last_q))
    else $error("run end did not return to parsing");
`endif

endmodule
